// ----- rtl/sgs_pkg.sv -----
// Shared types and constants for the shot group statistics block.
// Used by the controller, the datapath and the top level.
package sgs_pkg;
   localparam int COORD_W   = 20;
   localparam int DIST_W    = 21;
   localparam int MAX_HITS  = 64;
   localparam int FRAC_BITS = 10;

   typedef enum logic [8:0] {
      ST_LOAD  = 9'b000000001,
      ST_SUM   = 9'b000000010,
      ST_CDIV  = 9'b000000100,
      ST_PAIR  = 9'b000001000,
      ST_RAD   = 9'b000010000,
      ST_MDIV  = 9'b000100000,
      ST_VAR   = 9'b001000000,
      ST_VDIV  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic store;
      logic clear;
      logic sum_start;
      logic cdiv_start;
      logic pair_start;
      logic rad_start;
      logic mdiv_start;
      logic var_start;
      logic vdiv_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic done;
   } sts_type;
endpackage

// ----- rtl/shot_group_statistics.sv -----
// Top level of the shot group statistics block.
// Joins sgs_ctrl and sgs_datapath; depends on sgs_pkg.
//
// Hits arrive one per item on the req_ channel (hit_x, hit_y, last_hit) and
// load at one per cycle. An item with last_hit set closes the group: the
// input stalls while the block computes the centroid with a serial divider,
// walks all pairs for the largest spread through a bit-serial square root,
// takes every radius, the mean and the deviation. One result item appears
// on the rsp_ channel. The length of the closing pass is set mostly by the
// pair walk, which sends every pair through the one square root unit.
// Up to MAX_HITS hits are kept; later ones are dropped and flagged in
// overflowed. The result waits in its register while rsp_stall is high; the
// next group loads meanwhile, and its result waits until the register frees.
// Reset clears the hit count, the drop flag and the valid flag.
module shot_group_statistics (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [19:0] req_hit_x,
   input  logic signed [19:0] req_hit_y,
   input  logic               req_last_hit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_hit_total,
   output logic [20:0]        rsp_spread,
   output logic signed [19:0] rsp_mid_x,
   output logic signed [19:0] rsp_mid_y,
   output logic [20:0]        rsp_avg_radius,
   output logic [20:0]        rsp_radius_dev,
   output logic               rsp_overflowed
);
   import sgs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sgs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_last_hit(req_last_hit), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   sgs_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_hit_x(req_hit_x), .req_hit_y(req_hit_y),
      .rsp_hit_total(rsp_hit_total), .rsp_spread(rsp_spread),
      .rsp_mid_x(rsp_mid_x), .rsp_mid_y(rsp_mid_y),
      .rsp_avg_radius(rsp_avg_radius), .rsp_radius_dev(rsp_radius_dev),
      .rsp_overflowed(rsp_overflowed)
   );
endmodule

// ----- rtl/sgs_ctrl.sv -----
// Controller state machine for the shot group statistics block.
// Depends on sgs_pkg for the state, command and status types.
module sgs_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last_hit,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  sgs_pkg::sts_type sts,
   output sgs_pkg::cmd_type cmd
);
   import sgs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      acc;

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               cmd.store = !sts.full;
               if (req_last_hit) begin
                  state_in = ST_SUM;
                  cmd.sum_start = 1'b1;
               end
            end
         end
         ST_SUM: if (sts.done) begin state_in = ST_CDIV; cmd.cdiv_start = 1'b1; end
         ST_CDIV: if (sts.done) begin state_in = ST_PAIR; cmd.pair_start = 1'b1; end
         ST_PAIR: if (sts.done) begin state_in = ST_RAD; cmd.rad_start = 1'b1; end
         ST_RAD: if (sts.done) begin state_in = ST_MDIV; cmd.mdiv_start = 1'b1; end
         ST_MDIV: if (sts.done) begin state_in = ST_VAR; cmd.var_start = 1'b1; end
         ST_VAR: if (sts.done) begin state_in = ST_VDIV; cmd.vdiv_start = 1'b1; end
         ST_VDIV: if (sts.done) begin state_in = ST_OUT; end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               cmd.clear = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- rtl/sgs_datapath.sv -----
// Datapath for the shot group statistics block: hit memory, accumulators,
// a shared serial divider, a serial square root unit and the result register.
// Depends on sgs_pkg for command and status types.
module sgs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sgs_pkg::cmd_type       cmd,
   output sgs_pkg::sts_type       sts,
   input  logic signed [19:0]     req_hit_x,
   input  logic signed [19:0]     req_hit_y,
   output logic [6:0]             rsp_hit_total,
   output logic [20:0]            rsp_spread,
   output logic signed [19:0]     rsp_mid_x,
   output logic signed [19:0]     rsp_mid_y,
   output logic [20:0]            rsp_avg_radius,
   output logic [20:0]            rsp_radius_dev,
   output logic                   rsp_overflowed
);
   import sgs_pkg::*;

   localparam int AW = (MAX_HITS > 2) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int SW = COORD_W + CW + 1;
   localparam int RSW = DIST_W + CW;
   localparam int VW = 2 * DIST_W + CW + 2;
   localparam int DW = (VW > SW) ? VW : SW;
   localparam int QW = 43;

   logic signed [COORD_W-1:0] xmem [MAX_HITS];
   logic signed [COORD_W-1:0] ymem [MAX_HITS];
   logic [DIST_W-1:0]         rmem [MAX_HITS];

   logic [CW-1:0] cnt_ff;
   logic          drop_ff;
   logic          busy_ff, done_ff;
   logic [3:0]    phase_ff;
   logic [AW-1:0] i_ff, j_ff;
   logic [CW-1:0] k_ff;
   logic signed [COORD_W-1:0] xi_ff, yi_ff, xj_ff, yj_ff;
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [DIST_W-1:0] gsize_ff, mean_ff, sd_ff, rd_ff;
   logic [RSW-1:0] rsum_ff;
   logic [VW-1:0] vsum_ff;

   // divider
   logic [DW-1:0] dnum_ff, drem_ff;
   logic [CW-1:0] dden_ff;
   logic [6:0]    dstep_ff;
   logic          dneg_ff, dy_ff;
   // square root
   logic [QW-1:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic          sq_busy_ff;
   logic [DW:0]   dtrial;
   logic [QW-1:0] sq_t;

   logic [21:0] adx, ady;
   logic signed [21:0] ddx_ff, ddy_ff;
   logic [43:0] m2x_ff, m2y_ff;
   logic [DIST_W:0] rdiff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         xmem[cnt_ff[AW-1:0]] <= req_hit_x;
         ymem[cnt_ff[AW-1:0]] <= req_hit_y;
      end
      xi_ff <= xmem[i_ff];
      yi_ff <= ymem[i_ff];
      xj_ff <= xmem[j_ff];
      yj_ff <= ymem[j_ff];
      rd_ff <= rmem[i_ff];
   end

   assign sts.full = (cnt_ff == CW'(MAX_HITS));
   assign sts.done = done_ff;
   assign adx = ddx_ff[21] ? 22'(-ddx_ff) : 22'(ddx_ff);
   assign ady = ddy_ff[21] ? 22'(-ddy_ff) : 22'(ddy_ff);
   assign dtrial = {drem_ff, dnum_ff[DW-1]} - {{(DW+1-CW){1'b0}}, dden_ff};
   assign rdiff = (rd_ff >= mean_ff) ? {1'b0, rd_ff - mean_ff} : {1'b0, mean_ff - rd_ff};
   assign sq_t = sq_res_ff + sq_bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         drop_ff <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sq_busy_ff <= 1'b0;
         dy_ff <= 1'b0;
         phase_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.store) cnt_ff <= cnt_ff + 1'b1;
         else if (cmd.clear) cnt_ff <= '0;
         if (cmd.clear) drop_ff <= 1'b0;
         else if (cmd.sum_start && sts.full && !cmd.store) drop_ff <= 1'b1;
         // serial divider: one quotient bit per cycle
         if (dy_ff) begin
            if (dstep_ff != 0) begin
               if (!dtrial[DW]) begin
                  drem_ff <= dtrial[DW-1:0];
                  dnum_ff <= {dnum_ff[DW-2:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[DW-2:0], dnum_ff[DW-1]};
                  dnum_ff <= {dnum_ff[DW-2:0], 1'b0};
               end
               dstep_ff <= dstep_ff - 1'b1;
            end else begin
               dy_ff <= 1'b0;
            end
         end
         // serial square root: one result bit per cycle
         if (sq_busy_ff) begin
            if (sq_bit_ff != 0) begin
               if (sq_v_ff >= sq_t) begin
                  sq_v_ff <= sq_v_ff - sq_t;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end else begin
               sq_busy_ff <= 1'b0;
            end
         end
         if (cmd.sum_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd1; i_ff <= '0; k_ff <= '0;
            sx_ff <= '0; sy_ff <= '0;
         end
         if (cmd.cdiv_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd2;
         end
         if (cmd.pair_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd4; i_ff <= '0; j_ff <= '0;
            k_ff <= '0; gsize_ff <= '0;
         end
         if (cmd.rad_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd8; i_ff <= '0; k_ff <= '0; rsum_ff <= '0;
         end
         if (cmd.mdiv_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd10;
         end
         if (cmd.var_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd12; i_ff <= '0; k_ff <= '0; vsum_ff <= '0;
         end
         if (cmd.vdiv_start) begin
            busy_ff <= 1'b1; phase_ff <= 4'd13;
         end
         if (busy_ff) begin
            case (phase_ff)
               4'd1: begin
                  // accumulate sums, one hit per cycle (memory read is registered)
                  if (k_ff != 0) begin
                     sx_ff <= sx_ff + SW'(xi_ff);
                     sy_ff <= sy_ff + SW'(yi_ff);
                  end
                  if (k_ff == cnt_ff) begin
                     busy_ff <= 1'b0; done_ff <= 1'b1;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                     if (k_ff + 1'b1 < cnt_ff) i_ff <= AW'(k_ff + 1'b1);
                  end
               end
               4'd2: begin
                  dneg_ff <= sx_ff[SW-1];
                  dnum_ff <= DW'(sx_ff[SW-1] ? -sx_ff : sx_ff);
                  drem_ff <= '0; dden_ff <= cnt_ff; dstep_ff <= 7'(DW);
                  dy_ff <= 1'b1; phase_ff <= 4'd3;
               end
               4'd3: if (!dy_ff) begin
                  cx_ff <= COORD_W'(dneg_ff ? -dnum_ff : dnum_ff);
                  dneg_ff <= sy_ff[SW-1];
                  dnum_ff <= DW'(sy_ff[SW-1] ? -sy_ff : sy_ff);
                  drem_ff <= '0; dstep_ff <= 7'(DW);
                  dy_ff <= 1'b1; phase_ff <= 4'd15;
               end
               4'd15: if (!dy_ff) begin
                  cy_ff <= COORD_W'(dneg_ff ? -dnum_ff : dnum_ff);
                  busy_ff <= 1'b0; done_ff <= 1'b1;
               end
               4'd4: begin
                  // pair walk: set addresses for next pair, wait read
                  if (cnt_ff < 2 || ({1'b0, i_ff} >= cnt_ff - 1'b1)) begin
                     busy_ff <= 1'b0; done_ff <= 1'b1;
                  end else begin
                     if (k_ff == 0) j_ff <= i_ff + 1'b1;
                     k_ff <= CW'(1); phase_ff <= 4'd5;
                  end
               end
               4'd5: phase_ff <= 4'd6;
               4'd6: begin
                  ddx_ff <= 22'(xj_ff) - 22'(xi_ff);
                  ddy_ff <= 22'(yj_ff) - 22'(yi_ff);
                  phase_ff <= 4'd7; k_ff <= '0;
               end
               4'd7: begin
                  if (k_ff == 0) begin
                     m2x_ff <= adx * adx; m2y_ff <= ady * ady; k_ff <= CW'(1);
                  end else if (k_ff == 1) begin
                     sq_v_ff <= QW'(m2x_ff + m2y_ff);
                     sq_res_ff <= '0; sq_bit_ff <= QW'(1) << (QW - 1);
                     sq_busy_ff <= 1'b1; k_ff <= CW'(2);
                  end else if (!sq_busy_ff) begin
                     if (DIST_W'(sq_res_ff) > gsize_ff) gsize_ff <= DIST_W'(sq_res_ff);
                     k_ff <= '0;
                     if ({1'b0, j_ff} + 1'b1 < cnt_ff) begin
                        j_ff <= j_ff + 1'b1; k_ff <= CW'(1); phase_ff <= 4'd5;
                     end else begin
                        i_ff <= i_ff + 1'b1; phase_ff <= 4'd4;
                     end
                  end
               end
               4'd8: phase_ff <= 4'd9;
               4'd9: begin
                  if (k_ff == 0) begin
                     ddx_ff <= 22'(xi_ff) - 22'(cx_ff);
                     ddy_ff <= 22'(yi_ff) - 22'(cy_ff);
                     k_ff <= CW'(1);
                  end else if (k_ff == 1) begin
                     m2x_ff <= adx * adx; m2y_ff <= ady * ady; k_ff <= CW'(2);
                  end else if (k_ff == 2) begin
                     sq_v_ff <= QW'(m2x_ff + m2y_ff);
                     sq_res_ff <= '0; sq_bit_ff <= QW'(1) << (QW - 1);
                     sq_busy_ff <= 1'b1; k_ff <= CW'(3);
                  end else if (!sq_busy_ff) begin
                     rmem[i_ff] <= DIST_W'(sq_res_ff);
                     rsum_ff <= rsum_ff + RSW'(DIST_W'(sq_res_ff));
                     k_ff <= '0;
                     if ({1'b0, i_ff} + 1'b1 < cnt_ff) begin
                        i_ff <= i_ff + 1'b1; phase_ff <= 4'd8;
                     end else begin
                        busy_ff <= 1'b0; done_ff <= 1'b1;
                     end
                  end
               end
               4'd10: begin
                  dnum_ff <= DW'(rsum_ff); drem_ff <= '0; dden_ff <= cnt_ff;
                  dstep_ff <= 7'(DW); dy_ff <= 1'b1; phase_ff <= 4'd11;
               end
               4'd11: if (!dy_ff) begin
                  mean_ff <= DIST_W'(dnum_ff); busy_ff <= 1'b0; done_ff <= 1'b1;
               end
               4'd12: begin
                  // variance sum: k counts read latency
                  if (k_ff == 0) begin
                     k_ff <= CW'(1);
                  end else if (k_ff == 1) begin
                     m2x_ff <= 44'(rdiff) * 44'(rdiff); k_ff <= CW'(2);
                  end else begin
                     vsum_ff <= vsum_ff + VW'(m2x_ff);
                     k_ff <= '0;
                     if ({1'b0, i_ff} + 1'b1 < cnt_ff) i_ff <= i_ff + 1'b1;
                     else begin busy_ff <= 1'b0; done_ff <= 1'b1; end
                  end
               end
               4'd13: begin
                  if (cnt_ff < 2) begin
                     sd_ff <= '0; gsize_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b1;
                  end else begin
                     dnum_ff <= DW'(vsum_ff); drem_ff <= '0; dden_ff <= cnt_ff - 1'b1;
                     dstep_ff <= 7'(DW); dy_ff <= 1'b1; phase_ff <= 4'd14;
                     k_ff <= '0;
                  end
               end
               4'd14: begin
                  if (k_ff == 0) begin
                     if (!dy_ff) begin
                        sq_v_ff <= QW'(dnum_ff); sq_res_ff <= '0;
                        sq_bit_ff <= QW'(1) << (QW - 1); sq_busy_ff <= 1'b1;
                        k_ff <= CW'(1);
                     end
                  end else if (!sq_busy_ff) begin
                     sd_ff <= (sq_res_ff > QW'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                                 : DIST_W'(sq_res_ff);
                     busy_ff <= 1'b0; done_ff <= 1'b1;
                  end
               end
               default: busy_ff <= 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hit_total <= 7'(cnt_ff);
         rsp_spread <= gsize_ff;
         rsp_mid_x <= cx_ff;
         rsp_mid_y <= cy_ff;
         rsp_avg_radius <= mean_ff;
         rsp_radius_dev <= sd_ff;
         rsp_overflowed <= drop_ff;
      end
   end
endmodule

// ----- bench/shot_group_statistics_test.sv -----
// Self-checking testbench for shot_group_statistics: hit groups are queued,
// driven with random idling, and every result is checked against a predictor.
// Depends on sgs_pkg and the shot_group_statistics RTL.
module shot_group_statistics_test;
   import sgs_pkg::*;

   localparam int CAPACITY = MAX_HITS;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic last;
   } hit_item;

   typedef struct {
      logic [6:0] total;
      logic [DIST_W-1:0] spread;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [DIST_W-1:0] radius;
      logic [DIST_W-1:0] deviation;
      logic dropped;
   } group_stats;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [19:0] req_hit_x = 0;
   logic signed [19:0] req_hit_y = 0;
   logic req_last_hit = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [6:0] rsp_hit_total;
   logic [20:0] rsp_spread;
   logic signed [19:0] rsp_mid_x;
   logic signed [19:0] rsp_mid_y;
   logic [20:0] rsp_avg_radius;
   logic [20:0] rsp_radius_dev;
   logic rsp_overflowed;

   shot_group_statistics dut (.*);

   hit_item hits_pending[$];
   group_stats stats_expected[$];
   logic signed [COORD_W-1:0] held_x[CAPACITY];
   logic signed [COORD_W-1:0] held_y[CAPACITY];
   int held_count = 0;
   bit held_dropped = 0;
   int error_count = 0;
   bit hit_taken = 0;
   int req_idle = 0;
   int rsp_idle = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #50000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned distance(longint dx, longint dy);
      return root_floor(longint'(dx * dx + dy * dy));
   endfunction

   task automatic absorb_hit(hit_item h);
      group_stats s;
      longint sx, sy, cx, cy;
      longint unsigned spread, rsum, mean, vsum, dev, d, diff;
      longint unsigned radii[CAPACITY];
      int n;
      if (held_count < CAPACITY) begin
         held_x[held_count] = h.x;
         held_y[held_count] = h.y;
         held_count++;
      end else begin
         held_dropped = 1;
      end
      if (!h.last) return;
      n = held_count;
      sx = 0; sy = 0; spread = 0; rsum = 0; vsum = 0; dev = 0;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            d = distance(longint'(held_x[j]) - held_x[i], longint'(held_y[j]) - held_y[i]);
            if (d > spread) spread = d;
         end
         sx += held_x[i];
         sy += held_y[i];
      end
      cx = sx / n;
      cy = sy / n;
      for (int i = 0; i < n; i++) begin
         radii[i] = distance(longint'(held_x[i]) - cx, longint'(held_y[i]) - cy);
         rsum += radii[i];
      end
      mean = rsum / n;
      if (n >= 2) begin
         for (int i = 0; i < n; i++) begin
            diff = radii[i] >= mean ? radii[i] - mean : mean - radii[i];
            vsum += diff * diff;
         end
         dev = root_floor(vsum / (n - 1));
         if (dev > 64'h1FFFFF) dev = 64'h1FFFFF;
      end else begin
         spread = 0;
      end
      s.total = n[6:0];
      s.spread = spread[DIST_W-1:0];
      s.cx = cx[COORD_W-1:0];
      s.cy = cy[COORD_W-1:0];
      s.radius = mean[DIST_W-1:0];
      s.deviation = dev[DIST_W-1:0];
      s.dropped = held_dropped;
      stats_expected.insert(stats_expected.size(), s);
      held_count = 0;
      held_dropped = 0;
   endtask

   task automatic report(string field, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      hit_taken = 0;
      if (!reset && req_valid && !req_stall) begin
         hit_item h;
         h.x = req_hit_x;
         h.y = req_hit_y;
         h.last = req_last_hit;
         absorb_hit(h);
         hit_taken = 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         group_stats s;
         if (stats_expected.size() == 0) begin
            report("unexpected item", 1, 0);
         end else begin
            s = stats_expected.pop_front();
            if (rsp_hit_total !== s.total) report("hit_total", rsp_hit_total, s.total);
            if (rsp_spread !== s.spread) report("spread", rsp_spread, s.spread);
            if (rsp_mid_x !== s.cx) report("mid_x", rsp_mid_x, s.cx);
            if (rsp_mid_y !== s.cy) report("mid_y", rsp_mid_y, s.cy);
            if (rsp_avg_radius !== s.radius)
               report("avg_radius", rsp_avg_radius, s.radius);
            if (rsp_radius_dev !== s.deviation)
               report("radius_dev", rsp_radius_dev, s.deviation);
            if (rsp_overflowed !== s.dropped)
               report("overflowed", rsp_overflowed, s.dropped);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || hit_taken)) begin
         if (req_idle > 0) begin
            req_idle--;
            req_valid <= 0;
         end else if (hits_pending.size() > 200 && $urandom_range(0, 9) == 0) begin
            req_idle = $urandom_range(0, 4);
            req_valid <= 0;
         end else if (hits_pending.size() > 0) begin
            hit_item h;
            h = hits_pending.pop_front();
            req_hit_x <= h.x;
            req_hit_y <= h.y;
            req_last_hit <= h.last;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_idle > 0) begin
         rsp_idle--;
      end else if (hits_pending.size() > 200 && $urandom_range(0, 3) == 0) begin
         rsp_idle = $urandom_range(0, 4);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   function automatic logic signed [COORD_W-1:0] pick_coord(int mode, int center);
      int offset;
      case (mode)
         0: return COORD_W'($urandom_range(0, 20'hFFFFF));
         1: return ($urandom_range(0, 1)) ? 20'sh7FFFF : -20'sh80000;
         default: begin
            offset = $urandom_range(0, 4000);
            return COORD_W'(center + offset - 2000);
         end
      endcase
   endfunction

   task automatic queue_hit(int x, int y, bit last);
      hit_item h;
      h.x = COORD_W'(x);
      h.y = COORD_W'(y);
      h.last = last;
      hits_pending.insert(hits_pending.size(), h);
   endtask

   task automatic queue_group(int n, int mode);
      int cx, cy;
      cx = $urandom_range(0, 20'hFFFFF);
      cy = $urandom_range(0, 20'hFFFFF);
      if (cx > 500000 || cx < -500000) cx = cx / 2;
      for (int i = 0; i < n; i++)
         queue_hit(pick_coord(mode, cx), pick_coord(mode, cy), i == n - 1);
   endtask

   initial begin
      int queued, n;
      queue_hit(-524288, 524287, 1);
      queue_hit(-524288, -524288, 0);
      queue_hit(524287, 524287, 1);
      queue_hit(-524288, -524288, 0);
      queue_hit(524287, -524288, 0);
      queue_hit(-524288, 524287, 0);
      queue_hit(524287, 524287, 1);
      queue_hit(-3, -5, 0);
      queue_hit(0, 0, 1);
      queue_hit(100, 100, 0);
      queue_hit(100, 100, 1);
      queue_hit(0, 0, 1);
      queue_hit(-1, 7, 0);
      queue_hit(2, -9, 0);
      queue_hit(1000, 0, 1);
      queued = hits_pending.size();
      for (int g = 0; g < 3; g++) begin
         n = 64 + g * 3;
         queue_group(n, g == 0 ? 0 : 2);
         queued += n;
      end
      while (queued < 1850) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         queue_group(n, $urandom_range(0, 2));
         queued += n;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      while (hits_pending.size() > 0 || req_valid) @(posedge clock);
      while (stats_expected.size() > 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (error_count == 0 && stats_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
